FILE: design/clkcal_pkg.sv
// types, codes and calendar helpers for the 12-hour clock calendar
// no dependencies; imported by every module of the block
package clkcal_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  localparam logic [3:0]  HOUR_MAX   = 4'd12;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;
  localparam logic [6:0]  MINSEC_MOD = 7'd60;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;

  // divisibility by 25: y * inv(25) mod 2^14 <= floor((2^14 - 1) / 25)
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_LIM = 14'd655;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_SET_TIME = 2'd1,
    FUNC_SET_DATE = 2'd2
  } func_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [13:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic        new_pm;
    logic [5:0]  new_second;
    logic [5:0]  new_minute;
    logic [3:0]  new_hour;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        date_rolled;
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic        cur_pm;
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [3:0]  cur_hour;
  } out_item_t;

  typedef struct packed {
    logic  step;
    func_t func;
  } ctl_t;

  typedef struct packed {
    logic [3:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       pm;
  } time_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    prod  = {14'd0, y} * {14'd0, INV25};
    div25 = (prod[13:0] <= DIV25_LIM);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == 4'd0 || m > MONTH_MAX) begin
      return 5'd31;
    end else if (m == 4'd2 && leap) begin
      return 5'd29;
    end else begin
      return MONTH_DAYS[idx];
    end
  endfunction

endpackage

FILE: design/clkcal_time_unit.sv
// seconds, minutes, 12-hour hours and am/pm counters with set-time clamping
// depends on clkcal_pkg
module clkcal_time_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  clkcal_pkg::ctl_t    ctl,
  input  clkcal_pkg::in_item_t item,
  output clkcal_pkg::time_t   time_nxt,
  output logic                day_adv
);
  import clkcal_pkg::*;

  logic [3:0] hour_r;
  logic [5:0] minute_r;
  logic [5:0] second_r;
  logic       pm_r;

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [4:0] hour_inc;

  always_comb begin
    sec_inc  = {1'b0, second_r} + 7'd1;
    min_inc  = {1'b0, minute_r} + 7'd1;
    hour_inc = {1'b0, hour_r} + 5'd1;
    time_nxt = '{hour: hour_r, minute: minute_r, second: second_r, pm: pm_r};
    day_adv  = 1'b0;
    case (ctl.func)
      FUNC_TICK: begin
        if (sec_inc < MINSEC_MOD) begin
          time_nxt.second = sec_inc[5:0];
        end else begin
          time_nxt.second = 6'd0;
          if (min_inc < MINSEC_MOD) begin
            time_nxt.minute = min_inc[5:0];
          end else begin
            time_nxt.minute = 6'd0;
            if (hour_inc == {1'b0, HOUR_MAX}) begin
              time_nxt.hour = HOUR_MAX;
              time_nxt.pm   = !pm_r;
              day_adv       = pm_r;
            end else if (hour_inc > {1'b0, HOUR_MAX}) begin
              time_nxt.hour = 4'd1;
            end else begin
              time_nxt.hour = hour_inc[3:0];
            end
          end
        end
      end
      FUNC_SET_TIME: begin
        if (item.new_hour == 4'd0) begin
          time_nxt.hour = 4'd1;
        end else if (item.new_hour > HOUR_MAX) begin
          time_nxt.hour = HOUR_MAX;
        end else begin
          time_nxt.hour = item.new_hour;
        end
        time_nxt.minute = (item.new_minute > MINSEC_MAX) ? MINSEC_MAX : item.new_minute;
        time_nxt.second = (item.new_second > MINSEC_MAX) ? MINSEC_MAX : item.new_second;
        time_nxt.pm     = item.new_pm;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= HOUR_MAX;
      minute_r <= 6'd0;
      second_r <= 6'd0;
      pm_r     <= 1'b0;
    end else if (ctl.step) begin
      hour_r   <= time_nxt.hour;
      minute_r <= time_nxt.minute;
      second_r <= time_nxt.second;
      pm_r     <= time_nxt.pm;
    end
  end

endmodule

FILE: design/clkcal_date_unit.sv
// day, month and saturating year counters with leap years and set-date clamping
// depends on clkcal_pkg
module clkcal_date_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clkcal_pkg::ctl_t     ctl,
  input  clkcal_pkg::in_item_t item,
  input  logic                 day_adv,
  output clkcal_pkg::date_t    date_nxt
);
  import clkcal_pkg::*;

  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;

  logic [3:0]  set_month;
  logic [13:0] set_year;
  logic [13:0] leap_year_sel;
  logic        leap;
  logic [4:0]  len_cur;
  logic [4:0]  len_set;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;

  always_comb begin
    if (item.new_month == 4'd0) begin
      set_month = 4'd1;
    end else if (item.new_month > MONTH_MAX) begin
      set_month = MONTH_MAX;
    end else begin
      set_month = item.new_month;
    end
    set_year      = (item.new_year > YEAR_MAX) ? YEAR_MAX : item.new_year;
    leap_year_sel = (ctl.func == FUNC_SET_DATE) ? set_year : year_r;
    leap          = is_leap(leap_year_sel);
    len_cur       = month_len(month_r, leap);
    len_set       = month_len(set_month, leap);
    day_inc       = {1'b0, day_r} + 6'd1;
    month_inc     = {1'b0, month_r} + 5'd1;
    date_nxt      = '{day: day_r, month: month_r, year: year_r};
    case (ctl.func)
      FUNC_TICK: begin
        if (day_adv) begin
          if (day_inc > {1'b0, len_cur}) begin
            date_nxt.day = 5'd1;
            if (month_inc > {1'b0, MONTH_MAX}) begin
              date_nxt.month = 4'd1;
              if (year_r < YEAR_MAX) begin
                date_nxt.year = year_r + 14'd1;
              end
            end else begin
              date_nxt.month = month_inc[3:0];
            end
          end else begin
            date_nxt.day = day_inc[4:0];
          end
        end
      end
      FUNC_SET_DATE: begin
        if (item.new_day == 5'd0) begin
          date_nxt.day = 5'd1;
        end else if (item.new_day > len_set) begin
          date_nxt.day = len_set;
        end else begin
          date_nxt.day = item.new_day;
        end
        date_nxt.month = set_month;
        date_nxt.year  = set_year;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= 5'd1;
      month_r <= 4'd11;
      year_r  <= 14'd1991;
    end else if (ctl.step) begin
      day_r   <= date_nxt.day;
      month_r <= date_nxt.month;
      year_r  <= date_nxt.year;
    end
  end

endmodule

FILE: design/clock_calendar_12h_core.sv
// top level of the 12-hour clock calendar: input register, time and date units,
// result register; depends on clkcal_pkg, clkcal_time_unit, clkcal_date_unit
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | in_tdata, in_tuser (func)
//   out_    | out | out_tvalid/tready  | out_tdata
//
// one item per cycle unless out_tready stalls; an item's result loads from the
// input register; the counters update in the same cycle the result register loads
// reset gives 12:00:00 am, Nov 1 1991, with both registers empty
// a stalled result holds while one more item waits in the input register
module clock_calendar_12h_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // new_hour, new_minute, new_second, new_pm, new_day, new_month, new_year
  input  logic [clkcal_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func
  input  logic [clkcal_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cur_hour, cur_minute, cur_second, cur_pm, cur_day, cur_month, cur_year,
  // date_rolled, zero pad
  output logic [clkcal_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import clkcal_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  func_t     in_func_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  ctl_t      ctl;
  time_t     time_nxt;
  date_t     date_nxt;
  logic      day_adv;

  assign ctl.step  = in_valid_r && (!out_valid_r || out_tready);
  assign ctl.func  = in_func_r;
  assign in_tready = !in_valid_r || ctl.step;

  clkcal_time_unit u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .item     (in_item_r),
    .time_nxt (time_nxt),
    .day_adv  (day_adv)
  );

  clkcal_date_unit u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .item     (in_item_r),
    .day_adv  (day_adv),
    .date_nxt (date_nxt)
  );

  always_comb begin
    out_item_nxt.pad         = '0;
    out_item_nxt.date_rolled = day_adv && (in_func_r == FUNC_TICK);
    out_item_nxt.cur_year    = date_nxt.year;
    out_item_nxt.cur_month   = date_nxt.month;
    out_item_nxt.cur_day     = date_nxt.day;
    out_item_nxt.cur_pm      = time_nxt.pm;
    out_item_nxt.cur_second  = time_nxt.second;
    out_item_nxt.cur_minute  = time_nxt.minute;
    out_item_nxt.cur_hour    = time_nxt.hour;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item_t'(in_tdata);
      in_func_r <= func_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

endmodule

FILE: design/clkcal_checker.sv
// port-level checks on the 12-hour clock calendar and the bind that attaches them
// depends on clkcal_pkg and clock_calendar_12h_core
module clkcal_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [clkcal_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import clkcal_pkg::*;

  out_item_t res;
  assign res = out_item_t'(out_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.cur_hour >= 4'd1 && res.cur_hour <= HOUR_MAX &&
                   res.cur_minute <= MINSEC_MAX && res.cur_second <= MINSEC_MAX)
    else $error("time field out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.cur_day >= 5'd1 && res.cur_month >= 4'd1 &&
                   res.cur_month <= MONTH_MAX && res.cur_year <= YEAR_MAX &&
                   res.cur_day <= month_len(res.cur_month, is_leap(res.cur_year)))
    else $error("date field out of range");

  a_roll_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.date_rolled |-> res.cur_hour == HOUR_MAX &&
      res.cur_minute == 6'd0 && res.cur_second == 6'd0 && !res.cur_pm &&
      res.cur_day == 5'd1 || out_tvalid && res.date_rolled && res.cur_day != 5'd1 &&
      res.cur_hour == HOUR_MAX && res.cur_minute == 6'd0 && res.cur_second == 6'd0 &&
      !res.cur_pm)
    else $error("date rolled away from midnight");

endmodule

bind clock_calendar_12h_core clkcal_checker u_clkcal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/clock_calendar_12h_checker.sv
// result checker for the 12-hour clock calendar: keeps its own copy of the time and date,
// predicts the reading for every accepted item and compares each returned reading field
// by field; depends on clkcal_pkg
module clock_calendar_12h_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [clkcal_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [clkcal_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [clkcal_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import clkcal_pkg::*;

  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [3:0]  hour_q;
  logic        pm_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;

  out_item_t readings_q[$];

  function automatic bit leap(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_of(input int m, input int y);
    case (m)
      2: return leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  task automatic apply_item(input logic [1:0] code, input in_item_t d, output out_item_t r);
    int   h, mi, s, dd, mo, y;
    logic rolled;
    rolled = 1'b0;
    case (code)
      FUNC_TICK: begin
        s = int'(sec_q) + 1;
        if (s < 60) begin
          sec_q = 6'(s);
        end else begin
          sec_q = 6'd0;
          mi = int'(min_q) + 1;
          if (mi < 60) begin
            min_q = 6'(mi);
          end else begin
            min_q = 6'd0;
            h = int'(hour_q) + 1;
            if (h == 12) begin
              hour_q = 4'd12;
              if (!pm_q) begin
                pm_q = 1'b1;
              end else begin
                // midnight: next day
                pm_q = 1'b0;
                rolled = 1'b1;
                dd = int'(day_q) + 1;
                if (dd > days_of(int'(month_q), int'(year_q))) begin
                  day_q = 5'd1;
                  if (month_q < 4'd12) begin
                    month_q = month_q + 4'd1;
                  end else begin
                    month_q = 4'd1;
                    if (year_q < YEAR_MAX) year_q = year_q + 14'd1;
                  end
                end else begin
                  day_q = 5'(dd);
                end
              end
            end else begin
              hour_q = (h >= 13) ? 4'd1 : 4'(h);
            end
          end
        end
      end
      FUNC_SET_TIME: begin
        h = int'(d.new_hour);
        mi = int'(d.new_minute);
        s = int'(d.new_second);
        if (h == 0) h = 1;
        if (h > 12) h = 12;
        if (mi > 59) mi = 59;
        if (s > 59) s = 59;
        hour_q = 4'(h);
        min_q = 6'(mi);
        sec_q = 6'(s);
        pm_q = d.new_pm;
      end
      FUNC_SET_DATE: begin
        dd = int'(d.new_day);
        mo = int'(d.new_month);
        y = int'(d.new_year);
        if (mo == 0) mo = 1;
        if (mo > 12) mo = 12;
        if (y > 9999) y = 9999;
        if (dd == 0) dd = 1;
        if (dd > days_of(mo, y)) dd = days_of(mo, y);
        day_q = 5'(dd);
        month_q = 4'(mo);
        year_q = 14'(y);
      end
      default: begin
      end
    endcase
    r = '0;
    r.cur_hour = hour_q;
    r.cur_minute = min_q;
    r.cur_second = sec_q;
    r.cur_pm = pm_q;
    r.cur_day = day_q;
    r.cur_month = month_q;
    r.cur_year = year_q;
    r.date_rolled = rolled;
  endtask

  task automatic compare_field(input string field, input logic [13:0] want,
                               input logic [13:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      sec_q = 6'd0;
      min_q = 6'd0;
      hour_q = 4'd12;
      pm_q = 1'b0;
      day_q = 5'd1;
      month_q = 4'd11;
      year_q = 14'd1991;
      readings_q.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = readings_q.pop_front();
          got = out_item_t'(out_tdata);
          compare_field("cur_hour", 14'(want.cur_hour), 14'(got.cur_hour));
          compare_field("cur_minute", 14'(want.cur_minute), 14'(got.cur_minute));
          compare_field("cur_second", 14'(want.cur_second), 14'(got.cur_second));
          compare_field("cur_pm", 14'(want.cur_pm), 14'(got.cur_pm));
          compare_field("cur_day", 14'(want.cur_day), 14'(got.cur_day));
          compare_field("cur_month", 14'(want.cur_month), 14'(got.cur_month));
          compare_field("cur_year", want.cur_year, got.cur_year);
          compare_field("date_rolled", 14'(want.date_rolled), 14'(got.date_rolled));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_item(in_tuser, in_item_t'(in_tdata), want);
        readings_q.push_back(want);
      end
    end
    pending = readings_q.size();
  end

endmodule

FILE: bench/clock_calendar_12h_core_tb.sv
// testbench top for clock_calendar_12h_core: directed and random ticks and set commands
// with bursty input and a stalling receiver; depends on clkcal_pkg, the block and
// clock_calendar_12h_checker
module clock_calendar_12h_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clkcal_pkg::*;

  localparam int         N_ITEMS      = 850;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         DRAIN_CYCLES = 8;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int errors;
  int pending;
  int sent = 0;
  int burst_left = 1;
  int cycles = 0;
  bit hold_req = 1'b0;

  clock_calendar_12h_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  clock_calendar_12h_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t noise();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[IN_TDATA_W-1:0];
  endfunction

  function automatic logic [13:0] pick_year();
    case ($urandom_range(0, 5))
      0: return 14'($urandom_range(0, 9999));
      1: return 14'(4 * $urandom_range(0, 2499));
      2: return 14'(100 * $urandom_range(0, 99));
      3: return 14'(400 * $urandom_range(0, 24));
      4: return YEAR_MAX;
      default: return 14'($urandom_range(10000, 16383));
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic put_item(input logic [1:0] code, input in_item_t d);
    in_tvalid <= 1'b1;
    in_tuser <= code;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 9) < 4) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic set_time(input logic [3:0] h, input logic [5:0] m, input logic [5:0] s,
                          input logic pm);
    in_item_t d;
    d = noise();
    d.new_hour = h;
    d.new_minute = m;
    d.new_second = s;
    d.new_pm = pm;
    put_item(FUNC_SET_TIME, d);
  endtask

  task automatic set_date(input logic [4:0] dd, input logic [3:0] mo, input logic [13:0] y);
    in_item_t d;
    d = noise();
    d.new_day = dd;
    d.new_month = mo;
    d.new_year = y;
    put_item(FUNC_SET_DATE, d);
  endtask

  task automatic ticks(input int n);
    repeat (n) put_item(FUNC_TICK, noise());
  endtask

  // receiver: stretches of steady, random and periodic ready, plus one long hold-off
  initial begin
    int mode;
    int span;
    int k;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      k = $urandom_range(2, 5);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          2: out_tready <= ($urandom_range(0, 9) < 3);
          default: out_tready <= (c % k == 0);
        endcase
      end
    end
  end

  initial begin
    int kind;
    logic [3:0] mo;
    logic [4:0] dd;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_TICK;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    put_item(FUNC_TICK, noise());
    put_item(FUNC_SPARE, noise());
    set_time(0, 63, 63, 0);
    set_time(15, 60, 0, 1);
    set_time(13, 0, 59, 0);
    set_time(11, 59, 59, 0);
    ticks(1);
    set_time(12, 59, 59, 1);
    ticks(1);
    set_date(31, 12, 9999);
    set_time(11, 59, 59, 1);
    ticks(1);
    set_date(29, 2, 1900);
    set_date(29, 2, 2000);
    set_date(29, 2, 2023);
    set_time(11, 59, 59, 1);
    ticks(1);
    set_date(0, 0, 16383);
    set_date(31, 15, 0);
    set_date(31, 13, 9998);
    set_time(11, 59, 59, 1);
    ticks(1);
    set_date(31, 4, 2024);
    set_date(31, 14, 10000);

    hold_req = 1'b1;
    while (sent < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        // set a date near a month end, go to just before noon or midnight, then tick across
        mo = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 12));
        dd = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(27, 31));
        set_date(dd, mo, pick_year());
        set_time(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd11,
                 ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) : 6'd59,
                 6'($urandom_range(45, 63)), 1'($urandom_range(0, 1)));
        ticks($urandom_range(1, 20));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 5)) put_item(2'($urandom_range(0, 3)), noise());
      end else if (kind < 90) begin
        set_time(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        ticks($urandom_range(0, 10));
      end else begin
        set_date(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), pick_year());
        ticks($urandom_range(1, 30));
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
